// File: src/gamma_pwm_frame_packer_core_assert.svh
// Assertion macros used by the RTL of the frame packer core.
`ifndef GAMMA_PWM_FRAME_PACKER_CORE_ASSERT_SVH
`define GAMMA_PWM_FRAME_PACKER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPFP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GPFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/gpfp_pkg.sv
package gpfp_pkg;

  localparam int unsigned PIXELS = 8;
  localparam int unsigned FRAME_PAIRS = (PIXELS / 2) < 1 ? 1 : (PIXELS / 2);
  localparam int unsigned PAIR_CNT_W = (FRAME_PAIRS > 1) ? $clog2(FRAME_PAIRS) : 1;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned GAMMA_W = 12;
  localparam int unsigned WORD_W = 6 * GAMMA_W;
  localparam int unsigned BYTES_PER_PAIR = WORD_W / 8;
  localparam int unsigned BYTE_CNT_W = $clog2(BYTES_PER_PAIR + 1);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // A complete pixel pair as it waits for the serializer.
  typedef struct packed {
    pixel_t first;
    pixel_t second;
    logic   frame_end;
  } pair_t;

  // The packed gamma word of one pair and its latch marker.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              frame_end;
  } frame_word_t;

endpackage

// File: src/gpfp_if.sv
interface gpfp_pix_if import gpfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface gpfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       latch_now;
  logic       last;

  modport source (output valid, output out_byte, output latch_now, output last,
                  input ready);
  modport sink (input valid, input out_byte, input latch_now, input last,
                output ready);
endinterface

// File: src/gpfp_gamma.sv
module gpfp_gamma import gpfp_pkg::*; (
  input  pair_t       pair_i,
  output frame_word_t frame_o
);

  function automatic logic [GAMMA_W-1:0] gamma12(input logic [CHAN_W-1:0] v);
    logic [CHAN_W:0]       s;
    logic [2*CHAN_W+1:0]   sq;
    logic [GAMMA_W:0]      g;
    s  = {1'b0, v} + (CHAN_W+1)'(1);
    sq = s * s;
    g  = sq[GAMMA_W+4:4];
    gamma12 = g[GAMMA_W] ? {GAMMA_W{1'b1}} : g[GAMMA_W-1:0];
  endfunction

  assign frame_o.word = {gamma12(pair_i.first.blue), gamma12(pair_i.first.green),
                         gamma12(pair_i.first.red), gamma12(pair_i.second.blue),
                         gamma12(pair_i.second.green), gamma12(pair_i.second.red)};
  assign frame_o.frame_end = pair_i.frame_end;

endmodule

// File: src/gamma_pwm_frame_packer_core.sv
// Data path: the second pixel of a pair is registered into the pair buffer; once the
// serializer is free the pair is loaded into the shift register, which offers its first
// byte, and the ninth byte follows as the receiver takes the eight before it.
// Throughput: nine bytes per pixel pair, one byte per cycle while the receiver is ready,
// set by the single byte-wide output port and its shift register.
// Reset clears the pair phase, the frame pair counter and all valid flags at once.
module gamma_pwm_frame_packer_core import gpfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  gpfp_pix_if.sink    pix_i,
  gpfp_byte_if.source byte_o
);

`include "gamma_pwm_frame_packer_core_assert.svh"

  logic                  phase_q, phase_d;
  pixel_t                held_q, held_d;
  pixel_t                cur_pix;
  pair_t                 pair_q, pair_d;
  logic                  pair_valid_q, pair_valid_d;
  logic [PAIR_CNT_W-1:0] pairs_q, pairs_d;
  logic [WORD_W-1:0]     word_q, word_d;
  logic [BYTE_CNT_W-1:0] cnt_q, cnt_d;
  logic                  latch_q, latch_d;
  frame_word_t           frame_w;
  logic                  in_take, second_take, out_take, load, frame_end;

  gpfp_gamma u_gamma (
    .pair_i  (pair_q),
    .frame_o (frame_w)
  );

  assign cur_pix = '{red: pix_i.red, green: pix_i.green, blue: pix_i.blue};

  assign pix_i.ready = !phase_q || !pair_valid_q;
  assign in_take     = pix_i.valid && pix_i.ready;
  assign second_take = in_take && phase_q;
  assign out_take    = byte_o.valid && byte_o.ready;
  assign frame_end   = (pairs_q == PAIR_CNT_W'(FRAME_PAIRS - 1));
  assign load        = pair_valid_q &&
                       ((cnt_q == '0) || ((cnt_q == BYTE_CNT_W'(1)) && byte_o.ready));

  always_comb begin
    phase_d      = phase_q;
    held_d       = held_q;
    pairs_d      = pairs_q;
    pair_d       = pair_q;
    pair_valid_d = pair_valid_q && !load;
    if (in_take) begin
      phase_d = !phase_q;
      if (!phase_q) begin
        held_d = cur_pix;
      end
    end
    if (second_take) begin
      pair_d       = '{first: held_q, second: cur_pix, frame_end: frame_end};
      pair_valid_d = 1'b1;
      pairs_d      = frame_end ? '0 : pairs_q + PAIR_CNT_W'(1);
    end
  end

  always_comb begin
    word_d  = word_q;
    cnt_d   = cnt_q;
    latch_d = latch_q;
    if (load) begin
      word_d  = frame_w.word;
      cnt_d   = BYTE_CNT_W'(BYTES_PER_PAIR);
      latch_d = frame_w.frame_end;
    end else if (out_take) begin
      word_d = {word_q[WORD_W-9:0], 8'h00};
      cnt_d  = cnt_q - BYTE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= 1'b0;
      pairs_q      <= '0;
      pair_valid_q <= 1'b0;
      cnt_q        <= '0;
      held_q       <= '0;
    end else begin
      phase_q      <= phase_d;
      pairs_q      <= pairs_d;
      pair_valid_q <= pair_valid_d;
      cnt_q        <= cnt_d;
      held_q       <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q  <= pair_d;
    word_q  <= word_d;
    latch_q <= latch_d;
  end

  assign byte_o.valid     = (cnt_q != '0);
  assign byte_o.out_byte  = word_q[WORD_W-1:WORD_W-8];
  assign byte_o.last      = (cnt_q == BYTE_CNT_W'(1));
  assign byte_o.latch_now = byte_o.last && latch_q;

  `GPFP_ASSERT_SAME(a_latch_on_last, byte_o.valid && byte_o.latch_now, byte_o.last,
    "latch flag raised on a byte other than the ninth")
  `GPFP_ASSERT_SAME(a_pairs_in_range, 1'b1, pairs_q <= PAIR_CNT_W'(FRAME_PAIRS - 1),
    "frame pair counter out of range")
  `GPFP_ASSERT_NEXT(a_pair_held, pair_valid_q && !load, pair_valid_q && $stable(pair_q),
    "waiting pixel pair lost or changed")
  `GPFP_ASSERT_NEXT(a_drain_idle, out_take && byte_o.last && !pair_valid_q, !byte_o.valid,
    "byte offered with no pair loaded")
  `GPFP_ASSERT_NEXT(a_load_full, load, cnt_q == BYTE_CNT_W'(BYTES_PER_PAIR),
    "serializer not loaded with a full pair")

endmodule

// File: tb/tb_gamma_pwm_frame_packer_core.sv
`timescale 1ns / 1ps

module tb_gamma_pwm_frame_packer_core;
  import gpfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_PIXELS = 480;
  localparam int unsigned NUM_PHASES = 4;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned NUM_DIRECTED = 22;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       latch_now;
    logic       last;
  } pwm_byte_t;

  typedef struct {
    pixel_t            pix;
    bit                typed;
    logic [WORD_W-1:0] word;
  } pixel_row_t;

  logic clk_i;
  logic rst_ni;

  gpfp_pix_if  pix_if ();
  gpfp_byte_if byte_if ();

  gamma_pwm_frame_packer_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .byte_o (byte_if)
  );

  pwm_byte_t   pending_bytes[$];
  pixel_t      held_pix;
  bit          holding_first;
  int unsigned pairs_in_frame;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned long_holds_requested;
  int unsigned long_holds_started;

  // The unpacked pairs are typed in only where the gamma code is obviously 0 or 4095.
  pixel_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{8'd0,   8'd0,   8'd0  }, 1'b0, 72'h0},
    '{'{8'd0,   8'd0,   8'd0  }, 1'b1, 72'h000000000000000000},
    '{'{8'd255, 8'd255, 8'd255}, 1'b0, 72'h0},
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, 72'hFFFFFFFFFFFFFFFFFF},
    '{'{8'd255, 8'd0,   8'd0  }, 1'b0, 72'h0},
    '{'{8'd0,   8'd0,   8'd0  }, 1'b1, 72'h000000FFF000000000},
    '{'{8'd0,   8'd255, 8'd0  }, 1'b0, 72'h0},
    '{'{8'd0,   8'd0,   8'd0  }, 1'b1, 72'h000FFF000000000000},
    '{'{8'd0,   8'd0,   8'd255}, 1'b0, 72'h0},
    '{'{8'd0,   8'd0,   8'd0  }, 1'b1, 72'hFFF000000000000000},
    '{'{8'd0,   8'd0,   8'd0  }, 1'b0, 72'h0},
    '{'{8'd255, 8'd0,   8'd0  }, 1'b1, 72'h000000000000000FFF},
    '{'{8'd0,   8'd0,   8'd0  }, 1'b0, 72'h0},
    '{'{8'd0,   8'd255, 8'd0  }, 1'b1, 72'h000000000000FFF000},
    '{'{8'd0,   8'd0,   8'd0  }, 1'b0, 72'h0},
    '{'{8'd0,   8'd0,   8'd255}, 1'b1, 72'h000000000FFF000000},
    '{'{8'd254, 8'd1,   8'd128}, 1'b0, 72'h0},
    '{'{8'd127, 8'd64,  8'd3  }, 1'b0, 72'h0},
    '{'{8'd15,  8'd16,  8'd31 }, 1'b0, 72'h0},
    '{'{8'd85,  8'd170, 8'd204}, 1'b0, 72'h0},
    '{'{8'd1,   8'd2,   8'd4  }, 1'b0, 72'h0},
    '{'{8'd8,   8'd32,  8'd240}, 1'b0, 72'h0}
  };

  int unsigned phase_send_idle [NUM_PHASES] = '{0, 45, 0, 14};
  int unsigned phase_recv_stall [NUM_PHASES] = '{0, 0, 45, 14};

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic [GAMMA_W-1:0] gamma_code(input logic [CHAN_W-1:0] level);
    logic [17:0] squared;
    squared = ({10'd0, level} + 18'd1) * ({10'd0, level} + 18'd1);
    return (squared >> 4) > 18'd4095 ? 12'd4095 : squared[15:4];
  endfunction

  function automatic void take_pixel(input pixel_t pix, input bit typed,
                                     input logic [WORD_W-1:0] typed_word);
    logic [WORD_W-1:0] word;
    bit                frame_end;
    pwm_byte_t         entry;
    if (!holding_first) begin
      held_pix = pix;
      holding_first = 1'b1;
      return;
    end
    holding_first = 1'b0;
    word = {gamma_code(held_pix.blue), gamma_code(held_pix.green), gamma_code(held_pix.red),
            gamma_code(pix.blue), gamma_code(pix.green), gamma_code(pix.red)};
    if (typed) begin
      word = typed_word;
    end
    frame_end = (pairs_in_frame + 1 >= FRAME_PAIRS);
    for (int k = 0; k < BYTES_PER_PAIR; k++) begin
      entry.out_byte = word[WORD_W-1-8*k -: 8];
      entry.last = (k == BYTES_PER_PAIR - 1);
      entry.latch_now = entry.last && frame_end;
      pending_bytes.push_back(entry);
    end
    pairs_in_frame = frame_end ? 0 : pairs_in_frame + 1;
  endfunction

  task automatic send_pixel(input pixel_t pix, input bit typed,
                            input logic [WORD_W-1:0] typed_word);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.red <= pix.red;
    pix_if.green <= pix.green;
    pix_if.blue <= pix.blue;
    @(posedge clk_i);
    while (!pix_if.ready) begin
      @(posedge clk_i);
    end
    take_pixel(pix, typed, typed_word);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] random_level();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd254;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    byte_if.ready = 1'b0;
    long_holds_started = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && long_holds_started < long_holds_requested) begin
        long_holds_started++;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        byte_if.ready <= 1'b0;
      end else begin
        byte_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    pwm_byte_t exp_byte;
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      if (pending_bytes.size() == 0) begin
        $error("out_byte: no request expected, got %0h", byte_if.out_byte);
        mismatch_count++;
      end else begin
        exp_byte = pending_bytes.pop_front();
        if (byte_if.out_byte !== exp_byte.out_byte) begin
          $error("out_byte: expected %0h, got %0h", exp_byte.out_byte, byte_if.out_byte);
          mismatch_count++;
        end
        if (byte_if.latch_now !== exp_byte.latch_now) begin
          $error("latch_now: expected %0b, got %0b", exp_byte.latch_now, byte_if.latch_now);
          mismatch_count++;
        end
        if (byte_if.last !== exp_byte.last) begin
          $error("last: expected %0b, got %0b", exp_byte.last, byte_if.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[gamma_pwm_frame_packer_core] ERROR");
    $finish;
  end

  initial begin
    pixel_t pix;
    rst_ni = 1'b0;
    pix_if.valid = 1'b0;
    pix_if.red = '0;
    pix_if.green = '0;
    pix_if.blue = '0;
    held_pix = '0;
    holding_first = 1'b0;
    pairs_in_frame = 0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_holds_requested = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].word);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      send_idle_pct = phase_send_idle[phase];
      recv_stall_pct = phase_recv_stall[phase];
      if (phase == 0) begin
        long_holds_requested++;
      end
      for (int n = 0; n < RANDOM_PIXELS / NUM_PHASES; n++) begin
        pix.red = random_level();
        pix.green = random_level();
        pix.blue = random_level();
        send_pixel(pix, 1'b0, '0);
      end
    end
    pix_if.valid <= 1'b0;

    while (pending_bytes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[gamma_pwm_frame_packer_core] OK");
    end else begin
      $display("[gamma_pwm_frame_packer_core] ERROR");
    end
    $finish;
  end

endmodule
